// ===== src/ptt_pkg.sv =====
// Shared types, constants and helper functions for the periodic timer table.
package ptt_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TIME_WIDTH = 48;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam int NOW_W    = 48;
  localparam int MS_W     = 32;
  localparam int REPS_W   = 16;
  localparam int LATE_W   = 39;
  localparam int REM_W    = 48;
  localparam int PROD_W   = 42;
  localparam int MS_TO_US = 1000;

  // Wide enough for any sum of a time value and a period, plus a carry.
  localparam int WIDE_W = ((TIME_WIDTH > PROD_W) ? TIME_WIDTH : PROD_W) + 1;
  localparam int NOWX_W = (TIME_WIDTH > NOW_W) ? TIME_WIDTH : NOW_W;

  // Divide-by-1000 unit: one hex digit of the dividend per cycle.
  localparam int DIV_DIGITS = (TIME_WIDTH + 3) / 4;
  localparam int DIV_W      = DIV_DIGITS * 4;
  localparam int DREM_W     = 10;
  localparam int DCNT_W     = $clog2(DIV_DIGITS + 1);
  localparam int LCMP_W     = (DIV_W > LATE_W) ? DIV_W : LATE_W;
  localparam int RCMP_W     = (TIME_WIDTH > REM_W) ? TIME_WIDTH : REM_W;

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};
  localparam logic [LATE_W-1:0]     LATE_MAX = {LATE_W{1'b1}};
  localparam logic [REM_W-1:0]      REM_MAX  = {REM_W{1'b1}};

  // Command codes.
  localparam logic [2:0] A_ADD    = 3'd0;
  localparam logic [2:0] A_MODIFY = 3'd1;
  localparam logic [2:0] A_REMOVE = 3'd2;
  localparam logic [2:0] A_SCAN   = 3'd3;
  localparam logic [2:0] A_QUERY  = 3'd4;

  // Result codes.
  localparam logic [2:0] K_ADDED    = 3'd0;
  localparam logic [2:0] K_REJECTED = 3'd1;
  localparam logic [2:0] K_FIRED    = 3'd2;
  localparam logic [2:0] K_DEADLINE = 3'd3;
  localparam logic [2:0] K_NONE     = 3'd4;
  localparam logic [2:0] K_DONE     = 3'd5;

  typedef struct packed {
    logic [2:0]        action;
    logic [NOW_W-1:0]  now_us;
    logic [3:0]        slot;
    logic [MS_W-1:0]   timeout_ms;
    logic [REPS_W-1:0] repeat_count;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [3:0]        out_slot;
    logic [LATE_W-1:0] late_ms;
    logic [REM_W-1:0]  remaining_us;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] period;
    logic [TIME_WIDTH-1:0] deadline;
    logic [REPS_W-1:0]     repeats;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [TIME_WIDTH-1:0] to_time(input logic [NOW_W-1:0] t);
    logic [NOWX_W-1:0] ext;
    ext = NOWX_W'(t);
    return ext[TIME_WIDTH-1:0];
  endfunction

  function automatic rsp_t make_rsp(input logic [2:0] kind, input logic [3:0] s,
                                    input logic [LATE_W-1:0] late,
                                    input logic [REM_W-1:0] rem, input logic last);
    rsp_t r;
    r.kind         = kind;
    r.out_slot     = s;
    r.late_ms      = late;
    r.remaining_us = rem;
    r.last         = last;
    return r;
  endfunction

endpackage

// ===== src/periodic_timer_table.sv =====
// Top level of the periodic timer table: command sequencer around the entry RAM.
//
//  Channel  | Ports                       | Transfer
//  ---------+-----------------------------+------------------------------------------
//  command  | start, busy, cmd            | at a rising edge with start high, busy low
//  result   | rsp_strobe, rsp             | one cycle per result, cannot be held off
//  config   | cfg_write, cfg_data         | at a rising edge with cfg_write high
//
// Add and modify commands give their result from the check state, remove and unknown
// commands from the prep state. A scan or query walks the entry RAM at one slot per
// cycle, but a scan waits in the divide state while the divide-by-1000 unit handles
// each fired timer. A scan while stopped ends with no result; results are never stalled.
// Reset is synchronous: it clears the live and removed marks, the stopped bit and the
// sequencer. The entry RAM is not cleared since only live slots are ever read.
module periodic_timer_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ptt_pkg::cmd_t cmd,
  output logic          rsp_strobe,
  output ptt_pkg::rsp_t rsp,
  input  logic          cfg_write,
  input  logic          cfg_data
);
  import ptt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_END   = 3'd5;

  logic [2:0]            state;
  cmd_t                  req;
  logic [PROD_W-1:0]     period_r;
  logic [IDX_W-1:0]      idx;
  logic                  any_seen;
  logic [TIME_WIDTH-1:0] best;
  logic [NUM_TIMERS-1:0] live;
  logic [NUM_TIMERS-1:0] removed;
  logic                  stopped;

  // Entry RAM port signals.
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  entry_t                ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;
  entry_t                rd;

  // Divider signals.
  logic                  div_go;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quot;
  logic [TIME_WIDTH-1:0] late_diff;

  // Decoded request and arithmetic.
  logic [TIME_WIDTH-1:0] now_t;
  logic                  slot_ok;
  logic [IDX_W-1:0]      slot_idx;
  logic [WIDE_W-1:0]     new_sum;
  logic                  new_fits;
  logic [WIDE_W-1:0]     rearm_sum;
  logic [TIME_WIDTH-1:0] rearm_dl;
  logic                  fire;
  logic                  last_idx;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic [LCMP_W-1:0]     quot_wide;
  logic [LATE_W-1:0]     late_sat;
  logic [TIME_WIDTH-1:0] rem_diff;
  logic [RCMP_W-1:0]     rem_wide;
  logic [REM_W-1:0]      rem_sat;

  assign busy     = (state != S_IDLE);
  assign rd       = entry_t'(ram_rdata);
  assign now_t    = to_time(req.now_us);
  assign slot_ok  = (32'(req.slot) < NUM_TIMERS);
  assign slot_idx = IDX_W'(req.slot);
  assign last_idx = (idx == IDX_W'(NUM_TIMERS - 1));

  // A new deadline fits when now plus the period stays within the time range.
  assign new_sum   = WIDE_W'(now_t) + WIDE_W'(period_r);
  assign new_fits  = (new_sum <= WIDE_W'(TIME_MAX));
  assign rearm_sum = WIDE_W'(now_t) + WIDE_W'(rd.period);
  assign rearm_dl  = (rearm_sum <= WIDE_W'(TIME_MAX)) ? rearm_sum[TIME_WIDTH-1:0] : TIME_MAX;

  // A slot fires when it is live, not removed and its deadline has passed.
  assign fire      = live[idx] && !removed[idx] && (rd.deadline <= now_t);
  assign late_diff = now_t - rd.deadline;
  assign div_go    = (state == S_WALK) && (req.action == A_SCAN) && fire;

  // Lowest free slot for an add.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Saturation of the late and remaining times to their field widths.
  always_comb begin
    quot_wide = LCMP_W'(div_quot);
    late_sat  = (quot_wide > LCMP_W'(LATE_MAX)) ? LATE_MAX : quot_wide[LATE_W-1:0];
    rem_diff  = best - now_t;
    rem_wide  = RCMP_W'(rem_diff);
    if ((|(live & removed)) || (best <= now_t)) begin
      rem_sat = '0;
    end else if (rem_wide > RCMP_W'(REM_MAX)) begin
      rem_sat = REM_MAX;
    end else begin
      rem_sat = rem_wide[REM_W-1:0];
    end
  end

  // The read port always looks one slot ahead during a walk, so the next slot's
  // entry is ready in the cycle after the current one is done.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = rd;
    ram_raddr = idx + 1'b1;
    unique case (state)
      S_PREP: begin
        ram_raddr = (req.action == A_MODIFY) ? slot_idx : '0;
      end
      S_CHECK: begin
        ram_raddr = idx;
        if (req.action == A_ADD) begin
          ram_we    = free_found && new_fits;
          ram_waddr = free_idx;
          ram_wdata = '{period: TIME_WIDTH'(period_r),
                        deadline: new_sum[TIME_WIDTH-1:0],
                        repeats: req.repeat_count};
        end else begin
          ram_we    = slot_ok && live[slot_idx] && !removed[slot_idx] && new_fits;
          ram_waddr = slot_idx;
          ram_wdata = '{period: TIME_WIDTH'(period_r),
                        deadline: new_sum[TIME_WIDTH-1:0],
                        repeats: rd.repeats};
        end
      end
      S_WALK: begin
        if (div_go) begin
          ram_we    = 1'b1;
          ram_wdata = '{period: rd.period,
                        deadline: rearm_dl,
                        repeats: (rd.repeats != '0) ? rd.repeats - 1'b1 : rd.repeats};
        end
      end
      S_IDLE, S_DIV, S_END: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rsp_strobe <= 1'b0;
    if (rst) begin
      state      <= S_IDLE;
      live       <= '0;
      removed    <= '0;
      stopped    <= 1'b0;
      idx        <= '0;
      any_seen   <= 1'b0;
    end else begin
      if (cfg_write) begin
        stopped <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            req   <= cmd;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          period_r <= PROD_W'(req.timeout_ms) * PROD_W'(MS_TO_US);
          idx      <= '0;
          any_seen <= 1'b0;
          unique case (req.action)
            A_ADD, A_MODIFY: begin
              state <= S_CHECK;
            end
            A_REMOVE: begin
              if (slot_ok && live[slot_idx]) begin
                removed[slot_idx] <= 1'b1;
              end
              rsp_strobe <= 1'b1;
              rsp        <= make_rsp(K_DONE, 4'd0, '0, '0, 1'b1);
              state      <= S_IDLE;
            end
            A_SCAN: begin
              state <= stopped ? S_IDLE : S_WALK;
            end
            A_QUERY: begin
              if (stopped || !(|live)) begin
                rsp_strobe <= 1'b1;
                rsp        <= make_rsp(K_NONE, 4'd0, '0, '0, 1'b1);
                state      <= S_IDLE;
              end else begin
                state <= S_WALK;
              end
            end
            default: begin
              rsp_strobe <= 1'b1;
              rsp        <= make_rsp(K_DONE, 4'd0, '0, '0, 1'b1);
              state      <= S_IDLE;
            end
          endcase
        end
        S_CHECK: begin
          rsp_strobe <= 1'b1;
          state      <= S_IDLE;
          if (req.action == A_ADD) begin
            if (free_found && new_fits) begin
              live[free_idx]    <= 1'b1;
              removed[free_idx] <= 1'b0;
              rsp <= make_rsp(K_ADDED, 4'(free_idx), '0, '0, 1'b1);
            end else begin
              rsp <= make_rsp(K_REJECTED, 4'd0, '0, '0, 1'b1);
            end
          end else begin
            rsp <= make_rsp(K_DONE, 4'd0, '0, '0, 1'b1);
          end
        end
        S_WALK: begin
          if (req.action == A_SCAN) begin
            if (fire) begin
              if (rd.repeats == REPS_W'(1)) begin
                removed[idx] <= 1'b1;
              end
              state <= S_DIV;
            end else begin
              idx   <= idx + 1'b1;
              state <= last_idx ? S_END : S_WALK;
            end
          end else begin
            if (live[idx] && (!any_seen || (rd.deadline < best))) begin
              best     <= rd.deadline;
              any_seen <= 1'b1;
            end
            idx   <= idx + 1'b1;
            state <= last_idx ? S_END : S_WALK;
          end
        end
        S_DIV: begin
          if (div_done) begin
            rsp_strobe <= 1'b1;
            rsp        <= make_rsp(K_FIRED, 4'(idx), late_sat, '0, 1'b0);
            idx        <= idx + 1'b1;
            state      <= last_idx ? S_END : S_WALK;
          end
        end
        S_END: begin
          rsp_strobe <= 1'b1;
          state      <= S_IDLE;
          if (req.action == A_SCAN) begin
            // Retire every slot that was removed, by command or by its last firing.
            live    <= live & ~removed;
            removed <= removed & ~live;
            rsp     <= make_rsp(K_DONE, 4'd0, '0, '0, 1'b1);
          end else begin
            rsp <= make_rsp(K_DEADLINE, 4'd0, '0, rem_sat, 1'b1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ptt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_TIMERS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ptt_div1000 u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (late_diff),
    .done     (div_done),
    .quotient (div_quot)
  );

`ifndef SYNTHESIS
  // A slot can only be marked removed while it is live.
  assert property (@(posedge clk) disable iff (rst) (removed & ~live) == '0)
    else $error("removed mark set on a slot that is not live");

  // The final result of a command is shown as the sequencer returns to idle.
  assert property (@(posedge clk) disable iff (rst) rsp_strobe && rsp.last |-> !busy)
    else $error("last result shown while still busy");

  // Results that are not last come only from a scan still in progress.
  assert property (@(posedge clk) disable iff (rst)
                   rsp_strobe && !rsp.last |-> busy && (rsp.kind == K_FIRED))
    else $error("non-final result outside a scan");

  // The divider is only started from the walk, never while a division is pending.
  assert property (@(posedge clk) disable iff (rst) div_go |=> (state == S_DIV))
    else $error("divider started without waiting for it");
`endif

endmodule

// ===== src/ptt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ptt_div1000.sv =====
// Sequential divide-by-1000 unit, one hex digit of the quotient per cycle.
module ptt_div1000 (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  logic [ptt_pkg::TIME_WIDTH-1:0]   dividend,
  output logic                             done,
  output logic [ptt_pkg::DIV_W-1:0]        quotient
);
  import ptt_pkg::*;

  logic              running;
  logic [DCNT_W-1:0] cnt;
  logic [DIV_W-1:0]  num;
  logic [DREM_W-1:0] rem;
  logic [13:0]       partial;
  logic [3:0]        qd;
  logic [13:0]       rem_next;

  // Partial remainder times sixteen plus the next digit stays below 16000.
  always_comb begin
    partial = {rem, num[DIV_W-1 -: 4]};
    qd = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (partial >= 14'(k * MS_TO_US)) begin
        qd = 4'(k);
      end
    end
    rem_next = partial - 14'(qd) * 14'(MS_TO_US);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (go) begin
      running <= 1'b1;
      cnt     <= DCNT_W'(DIV_DIGITS);
      num     <= DIV_W'(dividend);
      rem     <= '0;
    end else if (running) begin
      rem      <= rem_next[DREM_W-1:0];
      num      <= num << 4;
      quotient <= {quotient[DIV_W-5:0], qd};
      cnt      <= cnt - 1'b1;
      if (cnt == DCNT_W'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

endmodule
